@@ rtl/bqs_pkg.sv @@
// Types and constants shared by the biquadratic root solver and its channel interfaces.
// Depends on nothing; the interfaces, the solver and its testbench import it.
package bqs_pkg;

  localparam int InW      = 16;
  localparam int CoefBits = 16;
  localparam int FracBits = 16;
  localparam int SqFrac   = 30;
  localparam int CountW   = 3;
  localparam int RootW    = 32;
  localparam int MaxRoots = 4;

  localparam int MagW    = CoefBits;
  localparam int ProdW   = 2 * MagW;
  localparam int DiscW   = 2 * MagW + 1;
  localparam int SqSteps = (DiscW + 2 * SqFrac + 1) / 2;
  localparam int NumW    = ((MagW + SqFrac > SqSteps) ? MagW + SqFrac : SqSteps) + 1;
  localparam int DivDW   = NumW;
  localparam int DivNW   = NumW + 2 * FracBits;
  localparam int RtSteps = (DivNW + 1) / 2;
  localparam int RtExtW  = (RtSteps > RootW) ? RtSteps : RootW;
  localparam int NStg    = 4 + SqSteps + DivNW + RtSteps;

  localparam logic [RootW-1:0] MaxRoot = {1'b0, {(RootW - 1){1'b1}}};

  typedef enum logic [1:0] {RstNone, RstZero, RstPair} root_st_e;
  typedef enum logic [1:0] {ModeNone, ModeLin, ModeDbl, ModeTwo} mode_e;

  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    logic     inf;
    root_st_e st1;
    logic     sel1;
    root_st_e st2;
    logic     sel2;
  } ctx_t;

  typedef struct packed {
    mag_t             ua;
    mag_t             ub;
    mag_t             uc;
    logic [ProdW-1:0] b2;
    logic [ProdW-1:0] ac;
    logic             na;
    logic             nb;
    logic             nc;
    logic             za;
    logic             zb;
    logic             zc;
  } p1_t;

  typedef struct packed {
    ctx_t  ctx;
    mode_e mode;
    mag_t  ua;
    mag_t  ub;
    mag_t  uc;
  } pre_t;

  typedef struct packed {
    logic [2*SqSteps-1:0] x;
    logic [SqSteps-1:0]   root;
    logic [SqSteps+1:0]   rem;
  } sq_t;

  typedef struct packed {
    logic [DivNW-1:0] nq;
    logic [DivDW-1:0] rem;
    logic [DivDW-1:0] den;
  } dv_t;

  typedef struct packed {
    logic [2*RtSteps-1:0] x;
    logic [RtSteps-1:0]   root;
    logic [RtSteps+1:0]   rem;
  } rt_t;

endpackage

@@ rtl/bqs_if.sv @@
// Request and result channel interfaces of the biquadratic root solver.
// Depends on bqs_pkg for field widths.
interface bqs_in_if import bqs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] coef_quartic;
  logic signed [InW-1:0] coef_square;
  logic signed [InW-1:0] coef_const;

  modport source(output valid, coef_quartic, coef_square, coef_const, input ready);
  modport sink(input valid, coef_quartic, coef_square, coef_const, output ready);
endinterface

interface bqs_out_if import bqs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    infinite_roots;
  logic [CountW-1:0]       root_count;
  logic signed [RootW-1:0] root_zero;
  logic signed [RootW-1:0] root_one;
  logic signed [RootW-1:0] root_two;
  logic signed [RootW-1:0] root_three;

  modport source(output valid, infinite_roots, root_count, root_zero, root_one, root_two,
                 root_three, input ready);
  modport sink(input valid, infinite_roots, root_count, root_zero, root_one, root_two,
               root_three, output ready);
endinterface

@@ rtl/biquadratic_root_solver.sv @@
// Biquadratic root solver: real roots of a*x^4 + b*x^2 + c = 0 in Q15.16.
// Depends on bqs_pkg and the bqs_in_if / bqs_out_if channel interfaces.
//
// Usage:
//   in_i carries one request of three signed coefficients; out_o returns one
//   result per request: infinite_roots, root_count and four roots in order.
//   The pipeline holds input, product and discriminant stages, one stage per bit
//   of the discriminant square root (47), a divider operand stage, one per
//   quotient bit of the two parallel restoring dividers (80), one per bit of
//   the root square roots (40), and the result register.
//   Throughput is one request per cycle while the pipeline advances. The whole
//   pipeline advances together whenever the result register is empty or its
//   result is being taken.
//   When the receiver stalls, the result is held and the pipeline freezes,
//   so in_i.ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset and there
//   is no clearing pass.
module biquadratic_root_solver import bqs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  bqs_in_if.sink    in_i,
  bqs_out_if.source out_o
);

  logic adv;

  logic [NStg-1:0] vld_q;
  logic            out_vld_q;

  logic signed [CoefBits-1:0] a_q, b_q, c_q;
  p1_t  p1_d, p1_q;
  pre_t pre_d;
  sq_t  sq0_d;
  pre_t pre_q [0:SqSteps];
  sq_t  sq_q  [0:SqSteps];
  dv_t  dva0_d, dvb0_d;
  dv_t  dva_q [0:DivNW];
  dv_t  dvb_q [0:DivNW];
  ctx_t cx_q  [0:DivNW];
  rt_t  ra0, rb0;
  rt_t  ra_q  [1:RtSteps];
  rt_t  rb_q  [1:RtSteps];
  ctx_t cr_q  [1:RtSteps];

  logic              inf_d, inf_q;
  logic [CountW-1:0] cnt_d, cnt_q;
  logic [RootW-1:0]  root_d [0:MaxRoots-1];
  logic [RootW-1:0]  root_q [0:MaxRoots-1];

  function automatic sq_t sq_step(sq_t s);
    logic [SqSteps+3:0] tmp;
    logic [SqSteps+3:0] trial;
    sq_t                r;
    tmp   = {s.rem, s.x[2*SqSteps-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.x   = {s.x[2*SqSteps-3:0], 2'b00};
    if (tmp >= trial) begin
      r.rem  = (SqSteps + 2)'(tmp - trial);
      r.root = {s.root[SqSteps-2:0], 1'b1};
    end else begin
      r.rem  = (SqSteps + 2)'(tmp);
      r.root = {s.root[SqSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic rt_t rt_step(rt_t s);
    logic [RtSteps+3:0] tmp;
    logic [RtSteps+3:0] trial;
    rt_t                r;
    tmp   = {s.rem, s.x[2*RtSteps-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.x   = {s.x[2*RtSteps-3:0], 2'b00};
    if (tmp >= trial) begin
      r.rem  = (RtSteps + 2)'(tmp - trial);
      r.root = {s.root[RtSteps-2:0], 1'b1};
    end else begin
      r.rem  = (RtSteps + 2)'(tmp);
      r.root = {s.root[RtSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    logic [DivDW:0] tmp;
    dv_t            r;
    tmp   = {s.rem, s.nq[DivNW-1]};
    r.den = s.den;
    if (tmp >= {1'b0, s.den}) begin
      r.rem = DivDW'(tmp - {1'b0, s.den});
      r.nq  = {s.nq[DivNW-2:0], 1'b1};
    end else begin
      r.rem = DivDW'(tmp);
      r.nq  = {s.nq[DivNW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [RootW-1:0] sat_root(logic [RtSteps-1:0] r);
    logic [RtExtW-1:0] e;
    e = RtExtW'(r);
    if (e > RtExtW'(MaxRoot)) begin
      return MaxRoot;
    end
    return RootW'(e);
  endfunction

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // magnitudes, signs and products
  always_comb begin
    p1_d.na = a_q[CoefBits-1];
    p1_d.nb = b_q[CoefBits-1];
    p1_d.nc = c_q[CoefBits-1];
    p1_d.za = (a_q == '0);
    p1_d.zb = (b_q == '0);
    p1_d.zc = (c_q == '0);
    p1_d.ua = a_q[CoefBits-1] ? MagW'(-a_q) : MagW'(a_q);
    p1_d.ub = b_q[CoefBits-1] ? MagW'(-b_q) : MagW'(b_q);
    p1_d.uc = c_q[CoefBits-1] ? MagW'(-c_q) : MagW'(c_q);
    p1_d.b2 = p1_d.ub * p1_d.ub;
    p1_d.ac = p1_d.ua * p1_d.uc;
  end

  // discriminant and root bookkeeping
  always_comb begin
    logic [DiscW-1:0] b2x;
    logic [DiscW-1:0] ac4x;
    logic [DiscW-1:0] dm;
    logic             dpos;
    logic             dneg;
    b2x  = DiscW'(p1_q.b2);
    ac4x = DiscW'({p1_q.ac, 2'b00});
    dm   = '0;
    dpos = 1'b0;
    dneg = 1'b0;
    pre_d.ctx.inf  = 1'b0;
    pre_d.ctx.st1  = RstNone;
    pre_d.ctx.sel1 = 1'b0;
    pre_d.ctx.st2  = RstNone;
    pre_d.ctx.sel2 = 1'b0;
    pre_d.mode     = ModeNone;
    pre_d.ua       = p1_q.ua;
    pre_d.ub       = p1_q.ub;
    pre_d.uc       = p1_q.uc;
    if (p1_q.za) begin
      if (p1_q.zb) begin
        pre_d.ctx.inf = p1_q.zc;
      end else begin
        pre_d.mode    = ModeLin;
        pre_d.ctx.st1 = p1_q.zc ? RstZero : ((p1_q.nb != p1_q.nc) ? RstPair : RstNone);
      end
    end else begin
      if (p1_q.zc || (p1_q.na != p1_q.nc)) begin
        dm   = b2x + ac4x;
        dpos = (dm != '0);
      end else if (b2x >= ac4x) begin
        dm   = b2x - ac4x;
        dpos = (dm != '0);
      end else begin
        dneg = 1'b1;
      end
      if (!dneg && !dpos) begin
        pre_d.mode    = ModeDbl;
        pre_d.ctx.st1 = p1_q.zb ? RstZero : ((p1_q.nb != p1_q.na) ? RstPair : RstNone);
      end else if (dpos) begin
        pre_d.mode     = ModeTwo;
        pre_d.ctx.sel1 = p1_q.nb;
        pre_d.ctx.sel2 = !p1_q.nb && !p1_q.zb;
        if (p1_q.nb) begin
          pre_d.ctx.st1 = p1_q.zc ? RstZero : (p1_q.nc ? RstNone : RstPair);
        end else begin
          pre_d.ctx.st1 = p1_q.na ? RstPair : RstNone;
        end
        if (p1_q.nb || p1_q.zb) begin
          pre_d.ctx.st2 = p1_q.na ? RstNone : RstPair;
        end else begin
          pre_d.ctx.st2 = p1_q.zc ? RstZero : (p1_q.nc ? RstPair : RstNone);
        end
      end
    end
    sq0_d.x    = (2 * SqSteps)'({dm, {(2 * SqFrac){1'b0}}});
    sq0_d.root = '0;
    sq0_d.rem  = '0;
  end

  // divider operands
  always_comb begin
    logic [NumW-1:0] nbig;
    pre_t            p;
    p          = pre_q[SqSteps];
    nbig       = (NumW'(p.ub) << SqFrac) + NumW'(sq_q[SqSteps].root);
    dva0_d     = '0;
    dvb0_d     = '0;
    unique case (p.mode)
      ModeLin: begin
        dva0_d.nq  = DivNW'(p.uc) << (2 * FracBits);
        dva0_d.den = DivDW'(p.ub);
      end
      ModeDbl: begin
        dva0_d.nq  = DivNW'(p.ub) << (2 * FracBits);
        dva0_d.den = DivDW'({p.ua, 1'b0});
      end
      ModeTwo: begin
        dva0_d.nq  = DivNW'(nbig) << (2 * FracBits);
        dva0_d.den = DivDW'({p.ua, 1'b0}) << SqFrac;
        dvb0_d.nq  = DivNW'(p.uc) << (1 + SqFrac + 2 * FracBits);
        dvb0_d.den = nbig;
      end
      default: begin
      end
    endcase
  end

  assign ra0 = '{x: (2 * RtSteps)'(dva_q[DivNW].nq), root: '0, rem: '0};
  assign rb0 = '{x: (2 * RtSteps)'(dvb_q[DivNW].nq), root: '0, rem: '0};

  // result assembly
  always_comb begin
    logic [RootW-1:0] ra, rb, r1, r2;
    logic [RootW-1:0] s1a, s1b, s2a, s2b;
    logic [1:0]       c1, c2;
    ctx_t             cx;
    cx  = cr_q[RtSteps];
    ra  = sat_root(ra_q[RtSteps].root);
    rb  = sat_root(rb_q[RtSteps].root);
    r1  = cx.sel1 ? rb : ra;
    r2  = cx.sel2 ? rb : ra;
    s1a = '0;
    s1b = '0;
    s2a = '0;
    s2b = '0;
    unique case (cx.st1)
      RstPair: begin
        s1a = RootW'(0) - r1;
        s1b = r1;
        c1  = 2'd2;
      end
      RstZero: c1 = 2'd1;
      default: c1 = 2'd0;
    endcase
    unique case (cx.st2)
      RstPair: begin
        s2a = RootW'(0) - r2;
        s2b = r2;
        c2  = 2'd2;
      end
      RstZero: c2 = 2'd1;
      default: c2 = 2'd0;
    endcase
    inf_d = cx.inf;
    cnt_d = CountW'(c1) + CountW'(c2);
    unique case (c1)
      2'd2: begin
        root_d[0] = s1a;
        root_d[1] = s1b;
        root_d[2] = s2a;
        root_d[3] = s2b;
      end
      2'd1: begin
        root_d[0] = '0;
        root_d[1] = s2a;
        root_d[2] = s2b;
        root_d[3] = '0;
      end
      default: begin
        root_d[0] = s2a;
        root_d[1] = s2b;
        root_d[2] = '0;
        root_d[3] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NStg-2:0], in_i.valid};
      out_vld_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q      <= in_i.coef_quartic[CoefBits-1:0];
      b_q      <= in_i.coef_square[CoefBits-1:0];
      c_q      <= in_i.coef_const[CoefBits-1:0];
      p1_q     <= p1_d;
      pre_q[0] <= pre_d;
      sq_q[0]  <= sq0_d;
      for (int k = 0; k < SqSteps; k++) begin
        sq_q[k+1]  <= sq_step(sq_q[k]);
        pre_q[k+1] <= pre_q[k];
      end
      dva_q[0] <= dva0_d;
      dvb_q[0] <= dvb0_d;
      cx_q[0]  <= pre_q[SqSteps].ctx;
      for (int j = 0; j < DivNW; j++) begin
        dva_q[j+1] <= dv_step(dva_q[j]);
        dvb_q[j+1] <= dv_step(dvb_q[j]);
        cx_q[j+1]  <= cx_q[j];
      end
      ra_q[1] <= rt_step(ra0);
      rb_q[1] <= rt_step(rb0);
      cr_q[1] <= cx_q[DivNW];
      for (int k = 1; k < RtSteps; k++) begin
        ra_q[k+1] <= rt_step(ra_q[k]);
        rb_q[k+1] <= rt_step(rb_q[k]);
        cr_q[k+1] <= cr_q[k];
      end
      inf_q <= inf_d;
      cnt_q <= cnt_d;
      for (int k = 0; k < MaxRoots; k++) begin
        root_q[k] <= root_d[k];
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.infinite_roots = inf_q;
  assign out_o.root_count     = cnt_q;
  assign out_o.root_zero      = root_q[0];
  assign out_o.root_one       = root_q[1];
  assign out_o.root_two       = root_q[2];
  assign out_o.root_three     = root_q[3];

  a_inf_no_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && inf_q |-> cnt_q == '0)
    else $error("infinite result with roots");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> cnt_q <= CountW'(MaxRoots))
    else $error("root count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && cnt_q != CountW'(MaxRoots) |-> root_q[3] == '0)
    else $error("unused root slot not cleared");

  a_pair_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && cnt_q == CountW'(MaxRoots) |->
      (root_q[0] + root_q[1]) == '0 && (root_q[2] + root_q[3]) == '0)
    else $error("root pair not symmetric");

endmodule

@@ test/bqs_tb_if.sv @@
`timescale 1ns / 100ps
// Constants of the biquadratic root solver testbench.
// Depends on nothing; the channel interfaces live with the RTL in bqs_if.sv.
package bqs_tb_pkg;
  localparam int unsigned WatchdogLimit = 20000;
endpackage

@@ test/biquadratic_root_solver_tb.sv @@
`timescale 1ns / 100ps
// Testbench of biquadratic_root_solver: a directed table, then random coefficient
// sets, each result checked against a behavioural root predictor. Depends on bqs_pkg,
// bqs_in_if / bqs_out_if and bqs_tb_pkg.
module biquadratic_root_solver_tb import bqs_pkg::*, bqs_tb_pkg::*;;

  typedef struct packed {
    logic                    inf;
    logic [CountW-1:0]       cnt;
    logic [RootW-1:0]        r0;
    logic [RootW-1:0]        r1;
    logic [RootW-1:0]        r2;
    logic [RootW-1:0]        r3;
  } roots_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    bit                 fixed;
    roots_t             want;
  } row_t;

  logic clk_i, rst_ni;
  bqs_in_if  req_ch();
  bqs_out_if res_ch();

  biquadratic_root_solver DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch), .out_o(res_ch));

  roots_t      pending_roots[$];
  roots_t      fixed_roots[$];
  bit          fixed_flag[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int          send_idle, recv_idle;
  bit          recv_hold;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [127:0] isqrt128(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return {64'd0, r};
  endfunction

  function automatic void push_root(int st, logic [127:0] t, ref logic [31:0] v[4],
                                    ref int n);
    logic [127:0] r;
    if (st < 0) return;
    if (st == 0) begin
      v[n++] = '0;
      return;
    end
    r = isqrt128(t);
    if (r > 128'h7FFF_FFFF) r = 128'h7FFF_FFFF;
    v[n++] = -r[31:0];
    v[n++] = r[31:0];
  endfunction

  function automatic int sgn(longint x);
    return x > 0 ? 1 : (x < 0 ? -1 : 0);
  endfunction

  function automatic roots_t solve_biquad(logic signed [15:0] ai, logic signed [15:0] bi,
                                          logic signed [15:0] ci);
    longint       a, b, c, ua, ub, uc;
    int           sa, sb, sc, sac, sd, n, n1, n2;
    logic [31:0]  v[4];
    logic [127:0] dm, s, nbig, dbig, tbig, tsmall;
    roots_t       r;
    a = ai; b = bi; c = ci;
    ua = a < 0 ? -a : a; ub = b < 0 ? -b : b; uc = c < 0 ? -c : c;
    sa = sgn(a); sb = sgn(b); sc = sgn(c);
    n = 0;
    v = '{default: '0};
    r = '0;
    if (a == 0) begin
      if (b == 0) r.inf = (c == 0);
      else push_root(-(sc * sb), (128'(uc) << 32) / 128'(ub), v, n);
    end else begin
      sac = sa * sc;
      if (sac <= 0) dm = 128'(ub * ub) + 128'(4 * ua * uc);
      else if (ub * ub >= 4 * ua * uc) dm = 128'(ub * ub - 4 * ua * uc);
      else dm = '0;
      sd = (sac > 0 && ub * ub < 4 * ua * uc) ? -1 : (dm > 0 ? 1 : 0);
      if (sd == 0) begin
        push_root(-(sb * sa), (128'(ub) << 32) / 128'(2 * ua), v, n);
      end else if (sd > 0) begin
        s = isqrt128(dm << 60);
        nbig = (128'(ub) << 30) + s;
        dbig = 128'(2 * ua) << 30;
        tbig = (nbig << 32) / dbig;
        tsmall = (b == 0) ? tbig : ((128'(uc) << 63) / nbig);
        n1 = b >= 0 ? -1 : sac;
        n2 = b <= 0 ? 1 : -sac;
        push_root(n1 * sa, b >= 0 ? tbig : tsmall, v, n);
        push_root(n2 * sa, b > 0 ? tsmall : tbig, v, n);
      end
    end
    r.cnt = n[CountW-1:0];
    r.r0 = v[0]; r.r1 = v[1]; r.r2 = v[2]; r.r3 = v[3];
    return r;
  endfunction

  function automatic roots_t lit(bit inf, int cnt, logic [31:0] r0, logic [31:0] r1,
                                 logic [31:0] r2, logic [31:0] r3);
    roots_t r;
    r.inf = inf; r.cnt = cnt[CountW-1:0];
    r.r0 = r0; r.r1 = r1; r.r2 = r2; r.r3 = r3;
    return r;
  endfunction

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, bit fixed, roots_t want);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.coef_quartic <= a;
    req_ch.coef_square  <= b;
    req_ch.coef_const   <= c;
    pending_roots.push_back(solve_biquad(a, b, c));
    fixed_flag.push_back(fixed);
    fixed_roots.push_back(want);
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic rand_phase(int n);
    logic signed [15:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: begin a = $urandom; b = $urandom; c = $urandom; end
        1: begin a = $urandom_range(20) - 10; b = $urandom_range(40) - 20;
                 c = $urandom_range(20) - 10; end
        2: begin a = 0; b = $urandom; c = $urandom; end
        3: begin a = $urandom_range(30) + 1; b = -$urandom_range(2000);
                 c = $urandom_range(200); end
        4: begin a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000; b = $urandom;
                 c = $urandom_range(1) ? 16'sh8000 : 16'sh0001; end
        default: begin
          a = $urandom_range(100) - 50;
          b = 2 * a * ($urandom_range(20) - 10);
          c = (b / 2) * (b / 2) / (a == 0 ? 1 : a);
          if ($urandom_range(3) == 0) begin a = 0; b = 0; c = 0; end
        end
      endcase
      send_coefs(a, b, c, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    roots_t got, want;
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("biquadratic_root_solver test failed");
        $finish;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = lit(res_ch.infinite_roots, res_ch.root_count, res_ch.root_zero,
                  res_ch.root_one, res_ch.root_two, res_ch.root_three);
        if (pending_roots.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_roots.pop_front();
          if (fixed_flag.pop_front() && fixed_roots[0] != want) begin
            errors++;
            if (errors <= 10) $display("table row disagrees: %p vs %p", fixed_roots[0], want);
          end
          void'(fixed_roots.pop_front());
          if (got.inf !== want.inf || got.cnt !== want.cnt || got.r0 !== want.r0 ||
              got.r1 !== want.r1 || got.r2 !== want.r2 || got.r3 !== want.r3) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    row_t tbl[$];
    recv_hold = 1'b0; errors = 0; idle_cycles = 0;
    send_idle = 33; recv_idle = 82;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.coef_quartic = '0; req_ch.coef_square = '0; req_ch.coef_const = '0;
    tbl.push_back('{0, 0, 0, 1, lit(1, 0, 0, 0, 0, 0)});
    tbl.push_back('{0, 0, 5, 1, lit(0, 0, 0, 0, 0, 0)});
    tbl.push_back('{1, 0, 1, 1, lit(0, 0, 0, 0, 0, 0)});
    tbl.push_back('{0, 1, 0, 1, lit(0, 1, 0, 0, 0, 0)});
    tbl.push_back('{0, 1, -1, 1, lit(0, 2, 32'hFFFF_0000, 32'h0001_0000, 0, 0)});
    tbl.push_back('{1, 0, -1, 1, lit(0, 2, 32'hFFFF_0000, 32'h0001_0000, 0, 0)});
    tbl.push_back('{1, 0, 0, 1, lit(0, 1, 0, 0, 0, 0)});
    tbl.push_back('{1, -5, 4, 0, '0});
    tbl.push_back('{1, -4, 4, 0, '0});
    tbl.push_back('{1, 5, 4, 0, '0});
    tbl.push_back('{-1, 5, -4, 0, '0});
    tbl.push_back('{1, -3, 0, 0, '0});
    tbl.push_back('{-32768, -32768, -32768, 0, '0});
    tbl.push_back('{32767, 32767, 32767, 0, '0});
    tbl.push_back('{1, -32768, 1, 0, '0});
    tbl.push_back('{32767, 0, -1, 0, '0});
    tbl.push_back('{0, 1, -32768, 0, '0});
    tbl.push_back('{-32768, 32767, -32768, 0, '0});
    tbl.push_back('{-1, 0, 32767, 0, '0});
    tbl.push_back('{32767, -1, -32768, 0, '0});
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) send_coefs(tbl[i].a, tbl[i].b, tbl[i].c, tbl[i].fixed, tbl[i].want);
    rand_phase(600);
    drain();
    send_idle = 82; recv_idle = 33;
    rand_phase(600);
    send_idle = 0; recv_idle = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      rand_phase(250);
    join
    drain();
    rand_phase(450);
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("biquadratic_root_solver test passed");
    end else begin
      $display("biquadratic_root_solver test failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/bqs_pkg.sv
rtl/bqs_if.sv
rtl/biquadratic_root_solver.sv
test/bqs_tb_if.sv
test/biquadratic_root_solver_tb.sv
